// ----- rtl/mges_pkg.sv -----
// shared types, constants and the cordic arctangent table for the moon gravity step
// no dependencies
package mges_pkg;

    localparam int FRAC = 16;
    localparam int CORDIC_STEPS = 20;

    localparam logic [47:0] ANGLE_INIT = 48'(720 * 65536);
    localparam logic [23:0] HALF_TURN_Q = 24'(180 * 65536);
    localparam logic [25:0] QUARTER_TURN_Q = 26'(90 * 65536);
    localparam logic [46:0] PULL_MAX = {47{1'b1}};

    typedef enum logic [2:0] {
        CFG_GRAV_PARAM = 3'd0,
        CFG_INIT_OFF_X = 3'd1,
        CFG_INIT_OFF_Y = 3'd2,
        CFG_INIT_VEL_X = 3'd3,
        CFG_INIT_VEL_Y = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic               cmd;
        logic signed [63:0] planet_x;
        logic signed [63:0] planet_y;
        logic        [23:0] time_step;
    } t_in_beat;

    typedef struct packed {
        logic signed [63:0] moon_x;
        logic signed [63:0] moon_y;
        logic        [47:0] speed;
        logic        [47:0] swept_angle;
        logic               collided;
    } t_out_beat;

    // arctan(2^-i) in q16 degrees
    function automatic logic [21:0] fn_atan(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/mges_mul.sv -----
// iterative 64x64 unsigned multiplier, one 32x32 partial product per cycle
// depends on nothing but the clock and reset
module mges_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);
    logic [63:0]  r_a, r_b, r_pp;
    logic [127:0] r_acc;
    logic [1:0]   r_sh;
    logic [2:0]   r_cnt;
    logic         r_busy, r_pv, r_done;
    logic [31:0]  a_part, b_part;
    logic [127:0] pp_ext;

    assign a_part = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign b_part = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign pp_ext = {64'd0, r_pp} << {r_sh, 5'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_pv   <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_pv) begin
                    r_acc <= r_acc + pp_ext;
                end
                if (r_cnt != 3'd4) begin
                    r_pp  <= a_part * b_part;
                    r_sh  <= 2'({1'b0, r_cnt[1]} + {1'b0, r_cnt[0]});
                    r_pv  <= 1'b1;
                    r_cnt <= r_cnt + 3'd1;
                end else begin
                    r_pv   <= 1'b0;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ----- rtl/mges_divsqrt.sv -----
// shared restoring divider and integer square root, one bit per cycle
// one 129-bit subtract serves both modes
module mges_divsqrt (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_sqrt,
    input  logic [127:0] i_num,
    input  logic [127:0] i_den,
    output logic         o_done,
    output logic [127:0] o_res
);
    logic [127:0] r_n, r_r, r_q, r_d, r_bit;
    logic [6:0]   r_cnt;
    logic         r_sqrt, r_busy, r_done;
    logic [127:0] rem_sh, op_a, op_b;
    logic [128:0] diff;
    logic         ge, last;

    assign rem_sh = {r_r[126:0], r_n[127]};
    assign op_a   = r_sqrt ? r_n : rem_sh;
    // root and bit never overlap, so or is the sum
    assign op_b   = r_sqrt ? (r_q | r_bit) : r_d;
    assign diff   = {1'b0, op_a} - {1'b0, op_b};
    assign ge     = !diff[128];
    assign last   = r_sqrt ? (r_cnt == 7'd63) : (r_cnt == 7'd127);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_sqrt <= i_sqrt;
                r_n    <= i_num;
                r_d    <= i_den;
                r_r    <= '0;
                r_q    <= '0;
                r_bit  <= 128'd1 << 126;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_sqrt) begin
                    if (ge) begin
                        r_n <= diff[127:0];
                        r_q <= (r_q >> 1) | r_bit;
                    end else begin
                        r_q <= r_q >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_n <= r_n << 1;
                    r_r <= ge ? diff[127:0] : rem_sh;
                    r_q <= {r_q[126:0], ge};
                end
                r_cnt <= r_cnt + 7'd1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_q;
endmodule

// ----- rtl/mges_cordic.sv -----
// vectoring cordic giving atan2(|cross|, dot) in q16 degrees, clamped to a half turn
// uses the arctangent table of mges_pkg
module mges_cordic (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_neg,
    input  logic [29:0] i_ud,
    input  logic [29:0] i_uc,
    output logic        o_done,
    output logic [23:0] o_angle
);
    import mges_pkg::*;

    logic signed [33:0] r_x, r_y, xs, ys;
    logic signed [25:0] r_z, atan_s;
    logic [4:0]         r_i;
    logic               r_busy, r_done;

    assign xs     = r_x >>> r_i;
    assign ys     = r_y >>> r_i;
    assign atan_s = 26'(fn_atan(r_i));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // a negative dot is rotated by a quarter turn first
                if (i_neg && i_ud != 30'd0) begin
                    r_x <= 34'({4'd0, i_uc});
                    r_y <= 34'({4'd0, i_ud});
                    r_z <= QUARTER_TURN_Q;
                end else begin
                    r_x <= 34'({4'd0, i_ud});
                    r_y <= 34'({4'd0, i_uc});
                    r_z <= '0;
                end
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_s;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_s;
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_z < 0) begin
            o_angle = '0;
        end else if (r_z > $signed({2'b00, HALF_TURN_Q})) begin
            o_angle = HALF_TURN_Q;
        end else begin
            o_angle = r_z[23:0];
        end
    end

    assign o_done = r_done;
endmodule

// ----- rtl/moon_gravity_euler_step.sv -----
// moon gravity step top level: sequencer, state registers and channels
// depends on mges_pkg, mges_mul, mges_divsqrt and mges_cordic
//
// usage
// - input channel (i_in_valid / o_in_ready / i_in) takes one beat per step:
//   cmd 0 loads the moon from the init registers around the given planet,
//   cmd 1 advances one semi-implicit euler tick of length time_step
// - config channel (i_cfg_valid / o_cfg_ready, index + data) is always ready;
//   write it only while the block is idle
// - every input beat yields exactly one output beat (o_out_valid / i_out_ready)
// - an advance runs three 128-step divisions and two 64-step square roots on
//   the shared divider and its products on the shared 64x64 multiplier; when
//   the turn angle is accumulated it also runs the cordic; a load runs only
//   the speed products and one square root
// - one step at a time: o_in_ready is high only in idle
// - the output register lets the next beat be taken while the last result
//   waits; a stalled receiver only holds a finished step at its end
// - reset clears the moon state, sets the swept angle to 720 degrees and
//   zeroes the config registers
module moon_gravity_euler_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mges_pkg::t_in_beat   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mges_pkg::t_out_beat  o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data
);
    import mges_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_SHIFT, S_DIFF, S_DX2, S_DY2, S_DIST, S_GDT, S_DD, S_G,
        S_PX, S_PXD, S_PY, S_PYD, S_VEL, S_MX, S_MY, S_ANG0, S_NA, S_NB,
        S_P1, S_P2, S_P3, S_P4, S_ABS, S_SHR, S_CORD, S_UPD,
        S_SPD_X, S_SPD_Y, S_SPD, S_DONE
    } t_state;

    t_state r_state;

    // config registers
    logic [63:0] r_grav, r_off_x, r_off_y;
    logic [47:0] r_ivel_x, r_ivel_y;

    // architectural state
    logic [63:0] r_pos_x, r_pos_y, r_prev_px, r_prev_py;
    logic [47:0] r_vel_x, r_vel_y, r_pull_x, r_pull_y, r_angle;
    logic        r_have;

    // working registers of one step
    logic [63:0]  r_px, r_py;
    logic [23:0]  r_dt;
    logic [63:0]  r_ux, r_uy, r_g;
    logic         r_sx, r_sy;
    logic [127:0] r_acc, r_num;
    logic [47:0]  r_d, r_gx, r_gy, r_nx, r_ny, r_speed;
    logic [29:0]  r_ax, r_ay, r_bx, r_by;
    logic [63:0]  r_dot, r_cr;
    logic [61:0]  r_ud, r_uc;
    logic         r_dneg, r_collided, r_iss;

    logic          r_ovalid;
    t_out_beat     r_out;

    // shared unit hookup
    logic          mul_req, mul_start, mul_done;
    logic [63:0]   mul_a, mul_b;
    logic [127:0]  mul_prod;
    logic          ds_req, ds_start, ds_sqrt, ds_done;
    logic [127:0]  ds_num, ds_den, ds_res;
    logic          cor_start, cor_done;
    logic [23:0]   cor_angle;

    logic [47:0]   vabs_x, vabs_y, norm_max, pull_mag;
    logic [63:0]   prod_s, dx, dy, gain_x, gain_y;
    logic [59:0]   prod60;
    logic [48:0]   vsum_x, vsum_y, angle_sum;
    logic          prod_neg;

    function automatic logic [47:0] fn_abs48(input logic [47:0] v);
        return v[47] ? 48'(-v) : v;
    endfunction

    function automatic logic [47:0] fn_sat48(input logic [48:0] s);
        logic [47:0] r;
        if (s[48] != s[47]) begin
            r = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            r = s[47:0];
        end
        return r;
    endfunction

    assign vabs_x   = fn_abs48(r_vel_x);
    assign vabs_y   = fn_abs48(r_vel_y);
    assign norm_max = (r_nx > r_ny) ? r_nx : r_ny;
    assign pull_mag = (ds_res[127:47] != '0) ? {1'b0, PULL_MAX} : {1'b0, ds_res[46:0]};
    assign prod60   = mul_prod[59:0];
    assign dx       = r_px - r_pos_x;
    assign dy       = r_py - r_pos_y;
    assign vsum_x   = {r_vel_x[47], r_vel_x} + {r_gx[47], r_gx};
    assign vsum_y   = {r_vel_y[47], r_vel_y} + {r_gy[47], r_gy};
    assign gain_x   = mul_prod[79:16];
    assign gain_y   = mul_prod[79:16];
    assign angle_sum = {1'b0, r_angle} + {25'd0, cor_angle};

    // sign of the current dot or cross partial product
    always_comb begin
        case (r_state)
            S_P1:    prod_neg = r_pull_x[47] ^ r_gx[47];
            S_P2:    prod_neg = r_pull_y[47] ^ r_gy[47];
            S_P3:    prod_neg = r_pull_x[47] ^ r_gy[47];
            S_P4:    prod_neg = r_pull_y[47] ^ r_gx[47];
            default: prod_neg = 1'b0;
        endcase
        prod_s = prod_neg ? 64'(-{4'd0, prod60}) : {4'd0, prod60};
    end

    // operand selection for the shared units
    always_comb begin
        mul_req = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        ds_req  = 1'b0;
        ds_sqrt = 1'b0;
        ds_num  = '0;
        ds_den  = '0;
        case (r_state)
            S_DX2: begin
                mul_req = 1'b1; mul_a = r_ux; mul_b = r_ux;
            end
            S_DY2: begin
                mul_req = 1'b1; mul_a = r_uy; mul_b = r_uy;
            end
            S_GDT: begin
                mul_req = 1'b1; mul_a = r_grav; mul_b = {40'd0, r_dt};
            end
            S_DD: begin
                mul_req = 1'b1; mul_a = {16'd0, r_d}; mul_b = {16'd0, r_d};
            end
            S_PX: begin
                mul_req = 1'b1; mul_a = r_ux; mul_b = r_g;
            end
            S_PY: begin
                mul_req = 1'b1; mul_a = r_uy; mul_b = r_g;
            end
            S_MX: begin
                mul_req = 1'b1; mul_a = {16'd0, vabs_x}; mul_b = {40'd0, r_dt};
            end
            S_MY: begin
                mul_req = 1'b1; mul_a = {16'd0, vabs_y}; mul_b = {40'd0, r_dt};
            end
            S_P1: begin
                mul_req = 1'b1; mul_a = {34'd0, r_ax}; mul_b = {34'd0, r_bx};
            end
            S_P2: begin
                mul_req = 1'b1; mul_a = {34'd0, r_ay}; mul_b = {34'd0, r_by};
            end
            S_P3: begin
                mul_req = 1'b1; mul_a = {34'd0, r_ax}; mul_b = {34'd0, r_by};
            end
            S_P4: begin
                mul_req = 1'b1; mul_a = {34'd0, r_ay}; mul_b = {34'd0, r_bx};
            end
            S_SPD_X: begin
                mul_req = 1'b1; mul_a = {16'd0, vabs_x}; mul_b = {16'd0, vabs_x};
            end
            S_SPD_Y: begin
                mul_req = 1'b1; mul_a = {16'd0, vabs_y}; mul_b = {16'd0, vabs_y};
            end
            S_DIST: begin
                ds_req = 1'b1; ds_sqrt = 1'b1; ds_num = r_acc;
            end
            S_G: begin
                ds_req = 1'b1; ds_num = r_num; ds_den = r_acc;
            end
            S_PXD, S_PYD: begin
                ds_req = 1'b1; ds_num = r_acc; ds_den = {64'd0, r_d, 16'd0};
            end
            S_SPD: begin
                ds_req = 1'b1; ds_sqrt = 1'b1; ds_num = r_acc;
            end
            default: begin
            end
        endcase
    end

    assign mul_start = mul_req && !r_iss;
    assign ds_start  = ds_req && !r_iss;
    assign cor_start = (r_state == S_CORD) && !r_iss;

    mges_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    mges_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ds_start),
        .i_sqrt  (ds_sqrt),
        .i_num   (ds_num),
        .i_den   (ds_den),
        .o_done  (ds_done),
        .o_res   (ds_res)
    );

    mges_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_neg   (r_dneg),
        .i_ud    (r_ud[29:0]),
        .i_uc    (r_uc[29:0]),
        .o_done  (cor_done),
        .o_angle (cor_angle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_iss     <= 1'b0;
            r_ovalid  <= 1'b0;
            r_grav    <= '0;
            r_off_x   <= '0;
            r_off_y   <= '0;
            r_ivel_x  <= '0;
            r_ivel_y  <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_prev_px <= '0;
            r_prev_py <= '0;
            r_vel_x   <= '0;
            r_vel_y   <= '0;
            r_pull_x  <= '0;
            r_pull_y  <= '0;
            r_have    <= 1'b0;
            r_angle   <= ANGLE_INIT;
        end else begin
            // config beats
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GRAV_PARAM: r_grav   <= i_cfg_data;
                    CFG_INIT_OFF_X: r_off_x  <= i_cfg_data;
                    CFG_INIT_OFF_Y: r_off_y  <= i_cfg_data;
                    CFG_INIT_VEL_X: r_ivel_x <= i_cfg_data[47:0];
                    CFG_INIT_VEL_Y: r_ivel_y <= i_cfg_data[47:0];
                    default: begin
                    end
                endcase
            end

            // unit issue flag: set on start, cleared when the unit reports back
            if (mul_start || ds_start || cor_start) begin
                r_iss <= 1'b1;
            end else if (mul_done || ds_done || cor_done) begin
                r_iss <= 1'b0;
            end

            // the done state reloads the output register itself
            if (r_ovalid && i_out_ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_px       <= i_in.planet_x;
                        r_py       <= i_in.planet_y;
                        r_dt       <= i_in.time_step;
                        r_collided <= 1'b0;
                        r_state    <= i_in.cmd ? S_SHIFT : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_pos_x   <= r_px + r_off_x;
                    r_pos_y   <= r_py + r_off_y;
                    r_vel_x   <= r_ivel_x;
                    r_vel_y   <= r_ivel_y;
                    r_prev_px <= r_px;
                    r_prev_py <= r_py;
                    r_pull_x  <= '0;
                    r_pull_y  <= '0;
                    r_have    <= 1'b0;
                    r_angle   <= ANGLE_INIT;
                    r_state   <= S_SPD_X;
                end
                S_SHIFT: begin
                    // moon follows the planet's motion since the last tick
                    r_pos_x   <= r_pos_x + (r_px - r_prev_px);
                    r_pos_y   <= r_pos_y + (r_py - r_prev_py);
                    r_prev_px <= r_px;
                    r_prev_py <= r_py;
                    r_state   <= S_DIFF;
                end
                S_DIFF: begin
                    r_sx    <= dx[63];
                    r_sy    <= dy[63];
                    r_ux    <= dx[63] ? 64'(-dx) : dx;
                    r_uy    <= dy[63] ? 64'(-dy) : dy;
                    r_state <= S_DX2;
                end
                S_DX2: begin
                    if (mul_done) begin
                        r_acc   <= mul_prod;
                        r_state <= S_DY2;
                    end
                end
                S_DY2: begin
                    if (mul_done) begin
                        r_acc   <= r_acc + mul_prod;
                        r_state <= S_DIST;
                    end
                end
                S_DIST: begin
                    if (ds_done) begin
                        // whole meters
                        r_d <= ds_res[63:16];
                        if (ds_res[63:16] == '0) begin
                            r_collided <= 1'b1;
                            r_state    <= S_SPD_X;
                        end else begin
                            r_state <= S_GDT;
                        end
                    end
                end
                S_GDT: begin
                    if (mul_done) begin
                        r_num   <= mul_prod;
                        r_state <= S_DD;
                    end
                end
                S_DD: begin
                    if (mul_done) begin
                        r_acc   <= mul_prod;
                        r_state <= S_G;
                    end
                end
                S_G: begin
                    if (ds_done) begin
                        r_g     <= (ds_res[127:64] != '0) ? '1 : ds_res[63:0];
                        r_state <= S_PX;
                    end
                end
                S_PX: begin
                    if (mul_done) begin
                        r_acc   <= mul_prod;
                        r_state <= S_PXD;
                    end
                end
                S_PXD: begin
                    if (ds_done) begin
                        r_gx    <= r_sx ? 48'(-pull_mag) : pull_mag;
                        r_state <= S_PY;
                    end
                end
                S_PY: begin
                    if (mul_done) begin
                        r_acc   <= mul_prod;
                        r_state <= S_PYD;
                    end
                end
                S_PYD: begin
                    if (ds_done) begin
                        r_gy    <= r_sy ? 48'(-pull_mag) : pull_mag;
                        r_state <= S_VEL;
                    end
                end
                S_VEL: begin
                    r_vel_x <= fn_sat48(vsum_x);
                    r_vel_y <= fn_sat48(vsum_y);
                    r_state <= S_MX;
                end
                S_MX: begin
                    if (mul_done) begin
                        r_pos_x <= r_pos_x + (r_vel_x[47] ? 64'(-gain_x) : gain_x);
                        r_state <= S_MY;
                    end
                end
                S_MY: begin
                    if (mul_done) begin
                        r_pos_y <= r_pos_y + (r_vel_y[47] ? 64'(-gain_y) : gain_y);
                        r_state <= S_ANG0;
                    end
                end
                S_ANG0: begin
                    // turn angle only with a previous pull and two nonzero vectors
                    if (r_have && (r_pull_x != '0 || r_pull_y != '0)
                            && (r_gx != '0 || r_gy != '0)) begin
                        r_nx    <= fn_abs48(r_pull_x);
                        r_ny    <= fn_abs48(r_pull_y);
                        r_state <= S_NA;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_NA, S_NB: begin
                    // scale until the larger magnitude sits in [2^29, 2^30)
                    if (norm_max[47:30] != '0) begin
                        r_nx <= r_nx >> 1;
                        r_ny <= r_ny >> 1;
                    end else if (!norm_max[29]) begin
                        r_nx <= r_nx << 1;
                        r_ny <= r_ny << 1;
                    end else if (r_state == S_NA) begin
                        r_ax    <= r_nx[29:0];
                        r_ay    <= r_ny[29:0];
                        r_nx    <= fn_abs48(r_gx);
                        r_ny    <= fn_abs48(r_gy);
                        r_state <= S_NB;
                    end else begin
                        r_bx    <= r_nx[29:0];
                        r_by    <= r_ny[29:0];
                        r_state <= S_P1;
                    end
                end
                S_P1: begin
                    if (mul_done) begin
                        r_dot   <= prod_s;
                        r_state <= S_P2;
                    end
                end
                S_P2: begin
                    if (mul_done) begin
                        r_dot   <= r_dot + prod_s;
                        r_state <= S_P3;
                    end
                end
                S_P3: begin
                    if (mul_done) begin
                        r_cr    <= prod_s;
                        r_state <= S_P4;
                    end
                end
                S_P4: begin
                    if (mul_done) begin
                        r_cr    <= r_cr - prod_s;
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_dneg  <= r_dot[63];
                    r_ud    <= r_dot[63] ? 62'(-r_dot) : r_dot[61:0];
                    r_uc    <= r_cr[63] ? 62'(-r_cr) : r_cr[61:0];
                    r_state <= S_SHR;
                end
                S_SHR: begin
                    if (r_ud[61:30] != '0 || r_uc[61:30] != '0) begin
                        r_ud <= r_ud >> 1;
                        r_uc <= r_uc >> 1;
                    end else begin
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (cor_done) begin
                        r_angle <= angle_sum[48] ? '1 : angle_sum[47:0];
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_pull_x <= r_gx;
                    r_pull_y <= r_gy;
                    r_have   <= 1'b1;
                    r_state  <= S_SPD_X;
                end
                S_SPD_X: begin
                    if (mul_done) begin
                        r_acc   <= mul_prod;
                        r_state <= S_SPD_Y;
                    end
                end
                S_SPD_Y: begin
                    if (mul_done) begin
                        r_acc   <= r_acc + mul_prod;
                        r_state <= S_SPD;
                    end
                end
                S_SPD: begin
                    if (ds_done) begin
                        r_speed <= ds_res[47:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (!r_ovalid || i_out_ready) begin
                        r_out.moon_x      <= r_pos_x;
                        r_out.moon_y      <= r_pos_y;
                        r_out.speed       <= r_speed;
                        r_out.swept_angle <= r_angle;
                        r_out.collided    <= r_collided;
                        r_ovalid          <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;
endmodule
